// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is held.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/prrf_pkg.sv =====
// Types, constants and byte tables of the poll request/response framer.
package prrf_pkg;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RECEIVE = 1'b1;

	localparam logic [1:0] KIND_REQ     = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_LENGTH = 2'd1;
	localparam logic [1:0] STATUS_HEADER = 2'd2;
	localparam logic [1:0] STATUS_CRC    = 2'd3;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [4:0] FRAME_LEN = 5'd18;
	localparam logic [4:0] COUNT_MAX = 5'd19;
	localparam logic [4:0] HDR_END   = 5'd6;
	localparam logic [4:0] CRC_END   = 5'd16;

	localparam int         PAYLOAD_DEPTH = 10;
	localparam logic [3:0] PAYLOAD_LAST  = 4'd9;
	localparam logic [3:0] REQ_DATA_END  = 4'd10;
	localparam logic [3:0] REQ_CRC_LO    = 4'd10;
	localparam logic [3:0] REQ_CRC_HI    = 4'd11;

	typedef struct packed {
		logic       init;
		logic       load;
		logic [7:0] data;
	} crc_cmd_t;

	// Expected header of a response frame.
	function automatic logic [7:0] resp_hdr_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd3:    b = 8'h01;
			3'd4:    b = 8'h0A;
			3'd5:    b = 8'h12;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Data bytes 0 to 9 of a request frame.
	function automatic logic [7:0] req_byte(input logic [3:0] idx, input logic [15:0] reg_index);
		logic [7:0] b;
		case (idx)
			4'd3:    b = 8'h01;
			4'd4:    b = 8'h0A;
			4'd5:    b = 8'h0C;
			4'd6:    b = reg_index[7:0];
			4'd7:    b = reg_index[15:8];
			4'd8:    b = 8'h16;
			4'd9:    b = 8'h61;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/prrf_ram.sv =====
// Generic single-port-write, registered-read RAM.
module prrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/prrf_crc.sv =====
// Bit-serial CRC-16 unit, one polynomial step per cycle, shared by transmit and receive.
module prrf_crc (
	input  logic               clk,
	input  logic               arst_n,
	input  prrf_pkg::crc_cmd_t cmd,
	output logic [15:0]        crc,
	output logic               busy
);

	logic [15:0] crc_q;
	logic [2:0]  cnt_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= prrf_pkg::CRC_INIT;
			cnt_q  <= 3'd0;
			busy_q <= 1'b0;
		end else if (cmd.init) begin
			crc_q  <= prrf_pkg::CRC_INIT;
			busy_q <= 1'b0;
		end else if (cmd.load) begin
			// fold the byte in, then run eight shift steps
			crc_q  <= crc_q ^ {8'h00, cmd.data};
			cnt_q  <= 3'd0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ prrf_pkg::CRC_POLY) : (crc_q >> 1);
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign crc  = crc_q;
	assign busy = busy_q;

endmodule

// ===== rtl/core/poll_request_response_framer.sv =====
// Top level of the poll request/response framer with CRC-16 frame check.
// Request: each of the 10 data bytes is sent and loaded into the CRC unit, and the framer
// waits for the unit to go idle before the next; the CRC low and high bytes follow.
// Received byte: frame bytes 0 to 15 are loaded into the bit-serial CRC unit, which the
// framer waits on; a final byte adds a judging state, then a reject or 10 payload bytes.
// Reset clears the sequencer, count, header flag and output valid; CRC returns to 0xFFFF.
`include "assert_macros.svh"

module poll_request_response_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [15:0] reg_index,
	input  logic [7:0]  rx_byte,
	input  logic        rx_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        last
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_REQ_BYTE = 3'd1;
	localparam logic [2:0] ST_REQ_WAIT = 3'd2;
	localparam logic [2:0] ST_RX_WAIT  = 3'd3;
	localparam logic [2:0] ST_RX_JUDGE = 3'd4;
	localparam logic [2:0] ST_RD_ADDR  = 3'd5;
	localparam logic [2:0] ST_RD_DATA  = 3'd6;

	logic [2:0]  state_q;
	logic [3:0]  idx_q;
	logic [15:0] reg_index_q;
	logic [7:0]  byte_q;
	logic        rx_last_q;
	logic [4:0]  rx_count_q;
	logic        header_match_q;
	logic [7:0]  crc_low_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  status_q;
	logic        last_q;

	logic               accept;
	logic               out_free;
	logic [1:0]         judge_status;
	logic [15:0]        crc_w;
	logic               crc_busy;
	prrf_pkg::crc_cmd_t crc_cmd;
	logic               ram_we;
	logic [3:0]         ram_waddr;
	logic [7:0]         ram_rdata;
	logic [7:0]         req_data;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign req_data = prrf_pkg::req_byte(idx_q, reg_index_q);

	always_comb begin
		if (rx_count_q != prrf_pkg::FRAME_LEN) begin
			judge_status = prrf_pkg::STATUS_LENGTH;
		end else if (!header_match_q) begin
			judge_status = prrf_pkg::STATUS_HEADER;
		end else if (crc_w != {byte_q, crc_low_q}) begin
			judge_status = prrf_pkg::STATUS_CRC;
		end else begin
			judge_status = prrf_pkg::STATUS_OK;
		end
	end

	always_comb begin
		crc_cmd = '0;
		if (accept && op == prrf_pkg::OP_REQUEST) begin
			crc_cmd.init = 1'b1;
		end else if (accept && op == prrf_pkg::OP_RECEIVE
			&& rx_count_q < prrf_pkg::CRC_END) begin
			crc_cmd.load = 1'b1;
			crc_cmd.data = rx_byte;
		end else if (state_q == ST_REQ_BYTE && out_free) begin
			if (idx_q < prrf_pkg::REQ_DATA_END) begin
				crc_cmd.load = 1'b1;
				crc_cmd.data = req_data;
			end else if (idx_q == prrf_pkg::REQ_CRC_HI) begin
				crc_cmd.init = 1'b1;
			end
		end else if (state_q == ST_RX_JUDGE) begin
			crc_cmd.init = (judge_status == prrf_pkg::STATUS_OK) || out_free;
		end
	end

	assign ram_we    = accept && op == prrf_pkg::OP_RECEIVE && rx_count_q >= prrf_pkg::HDR_END
		&& rx_count_q < prrf_pkg::CRC_END;
	assign ram_waddr = 4'(rx_count_q - prrf_pkg::HDR_END);

	prrf_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crc_cmd),
		.crc    (crc_w),
		.busy   (crc_busy)
	);

	prrf_ram #(
		.WIDTH (8),
		.DEPTH (prrf_pkg::PAYLOAD_DEPTH)
	) u_payload (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx_byte),
		.re    (state_q == ST_RD_ADDR),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= 4'd0;
			rx_count_q     <= 5'd0;
			header_match_q <= 1'b1;
			crc_low_q      <= 8'h00;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						byte_q    <= rx_byte;
						rx_last_q <= rx_last;
						if (op == prrf_pkg::OP_REQUEST) begin
							// a request abandons any partial response
							reg_index_q    <= reg_index;
							idx_q          <= 4'd0;
							rx_count_q     <= 5'd0;
							header_match_q <= 1'b1;
							crc_low_q      <= 8'h00;
							state_q        <= ST_REQ_BYTE;
						end else begin
							if (rx_count_q < prrf_pkg::HDR_END
								&& rx_byte != prrf_pkg::resp_hdr_byte(rx_count_q[2:0])) begin
								header_match_q <= 1'b0;
							end
							if (rx_count_q == prrf_pkg::CRC_END) begin
								crc_low_q <= rx_byte;
							end
							if (rx_count_q != prrf_pkg::COUNT_MAX) begin
								rx_count_q <= rx_count_q + 5'd1;
							end
							state_q <= ST_RX_WAIT;
						end
					end
				end
				ST_REQ_BYTE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= prrf_pkg::KIND_REQ;
						status_q    <= prrf_pkg::STATUS_OK;
						last_q      <= (idx_q == prrf_pkg::REQ_CRC_HI);
						if (idx_q < prrf_pkg::REQ_DATA_END) begin
							out_byte_q <= req_data;
							state_q    <= ST_REQ_WAIT;
						end else if (idx_q == prrf_pkg::REQ_CRC_LO) begin
							out_byte_q <= crc_w[7:0];
							idx_q      <= prrf_pkg::REQ_CRC_HI;
						end else begin
							out_byte_q <= crc_w[15:8];
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_REQ_WAIT: begin
					if (!crc_busy) begin
						idx_q   <= idx_q + 4'd1;
						state_q <= ST_REQ_BYTE;
					end
				end
				ST_RX_WAIT: begin
					if (!crc_busy) begin
						state_q <= rx_last_q ? ST_RX_JUDGE : ST_IDLE;
					end
				end
				ST_RX_JUDGE: begin
					if (judge_status == prrf_pkg::STATUS_OK) begin
						rx_count_q     <= 5'd0;
						header_match_q <= 1'b1;
						crc_low_q      <= 8'h00;
						idx_q          <= 4'd0;
						state_q        <= ST_RD_ADDR;
					end else if (out_free) begin
						out_valid_q    <= 1'b1;
						kind_q         <= prrf_pkg::KIND_REJECT;
						out_byte_q     <= 8'h00;
						status_q       <= judge_status;
						last_q         <= 1'b1;
						rx_count_q     <= 5'd0;
						header_match_q <= 1'b1;
						crc_low_q      <= 8'h00;
						state_q        <= ST_IDLE;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= prrf_pkg::KIND_PAYLOAD;
						out_byte_q  <= ram_rdata;
						status_q    <= prrf_pkg::STATUS_OK;
						last_q      <= (idx_q == prrf_pkg::PAYLOAD_LAST);
						if (idx_q == prrf_pkg::PAYLOAD_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 4'd1;
							state_q <= ST_RD_ADDR;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last      = last_q;

	`ASSERT_CLK(a_accept_crc_idle, accept |-> !crc_busy, "request accepted while CRC unit busy")
	`ASSERT_NEVER(a_count_sat, rx_count_q > prrf_pkg::COUNT_MAX, "receive count past saturation")
	`ASSERT_CLK(a_reject_shape,
		out_valid_q && kind_q == prrf_pkg::KIND_REJECT
		|-> last_q && out_byte_q == 8'h00 && status_q != prrf_pkg::STATUS_OK,
		"malformed reject result")
	`ASSERT_CLK(a_rx_clear_after_judge,
		state_q == ST_RX_JUDGE && judge_status == prrf_pkg::STATUS_OK
		|=> rx_count_q == 5'd0 && crc_w == prrf_pkg::CRC_INIT,
		"receive state not cleared after judging")

endmodule

// ===== bench/poll_request_response_framer_tb.sv =====
// Self-checking bench for the poll request/response framer: random frames, gaps and stalls.
module poll_request_response_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam real CLK_PERIOD   = 4.0;
	localparam int  RESET_CYCLES = 9;
	localparam int  RANDOM_ITEMS = 200;
	localparam int  CALM_FROM    = 60;
	localparam int  CALM_TO      = 140;
	localparam int  HOLD_AT      = 80;
	localparam int  HOLD_CYCLES  = 700;
	localparam int  MID_DRAIN_AT = 170;
	localparam int  TAIL_CYCLES  = 200;
	localparam longint TIMEOUT_NS = 2_000_000;

	localparam logic [47:0] REQ_HEAD  = 48'h00_00_00_01_0A_0C;
	localparam logic [15:0] REQ_TAIL  = 16'h16_61;
	localparam logic [47:0] RESP_HEAD = 48'h00_00_00_01_0A_12;

	typedef enum int {FR_GOOD, FR_HEADER, FR_CRC, FR_SHORT, FR_LONG, FR_CUT} frame_fault_t;

	typedef struct {
		logic        op;
		logic [15:0] idx;
		logic [7:0]  data;
		logic        fin;
		int          gap;
		bit          drain;
	} poll_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] st;
		logic       fin;
	} framer_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        op        = prrf_pkg::OP_REQUEST;
	logic [15:0] reg_index = 16'h0000;
	logic [7:0]  rx_byte   = 8'h00;
	logic        rx_last   = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic        last;

	poll_request_response_framer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.reg_index (reg_index),
		.rx_byte   (rx_byte),
		.rx_last   (rx_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.out_byte  (out_byte),
		.status    (status),
		.last      (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	poll_item_t     poll_items[$];
	framer_result_t owed_bytes[$];

	// receive side of the predictor
	logic [4:0]  rx_cnt;
	logic [15:0] rx_crc;
	logic        rx_hdr_ok;
	logic [7:0]  rx_payload [prrf_pkg::PAYLOAD_DEPTH];
	logic [7:0]  rx_crc_lo;

	int n_items      = 0;
	int n_accepted   = 0;
	int n_requests   = 0;
	int n_results    = 0;
	int n_req_bytes  = 0;
	int n_pay_bytes  = 0;
	int n_mismatches = 0;
	int rejects_by_status [4] = '{default: 0};
	bit drain_next   = 1'b0;

	poll_item_t next_item;
	bit         staged    = 1'b0;
	int         rdy_wait  = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ prrf_pkg::CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic rx_restart();
		rx_cnt    = '0;
		rx_crc    = prrf_pkg::CRC_INIT;
		rx_hdr_ok = 1'b1;
		rx_crc_lo = '0;
	endtask

	task automatic owe(input logic [1:0] k, input logic [7:0] d, input logic [1:0] s,
			input logic f);
		framer_result_t r;
		r.kind = k;
		r.data = d;
		r.st   = s;
		r.fin  = f;
		owed_bytes.push_back(r);
	endtask

	// Work out the results that one accepted request causes.
	task automatic predict_item(input logic opv, input logic [15:0] idx, input logic [7:0] b,
			input logic fin);
		logic [7:0]  frame [12];
		logic [15:0] crc;
		logic [1:0]  st;
		if (opv == prrf_pkg::OP_REQUEST) begin
			for (int i = 0; i < 6; i++)
				frame[i] = REQ_HEAD[8 * (5 - i) +: 8];
			frame[6] = idx[7:0];
			frame[7] = idx[15:8];
			frame[8] = REQ_TAIL[15:8];
			frame[9] = REQ_TAIL[7:0];
			crc = prrf_pkg::CRC_INIT;
			for (int i = 0; i < 10; i++)
				crc = crc16_step(crc, frame[i]);
			frame[10] = crc[7:0];
			frame[11] = crc[15:8];
			rx_restart();
			for (int i = 0; i < 12; i++)
				owe(prrf_pkg::KIND_REQ, frame[i], prrf_pkg::STATUS_OK, i == 11);
		end else begin
			if (rx_cnt < prrf_pkg::CRC_END) begin
				rx_crc = crc16_step(rx_crc, b);
				if (rx_cnt < prrf_pkg::HDR_END) begin
					if (b != RESP_HEAD[8 * (5 - rx_cnt) +: 8])
						rx_hdr_ok = 1'b0;
				end else begin
					rx_payload[rx_cnt - prrf_pkg::HDR_END] = b;
				end
			end else if (rx_cnt == prrf_pkg::CRC_END) begin
				rx_crc_lo = b;
			end
			if (rx_cnt < prrf_pkg::COUNT_MAX)
				rx_cnt++;
			if (fin) begin
				if (rx_cnt != prrf_pkg::FRAME_LEN)
					st = prrf_pkg::STATUS_LENGTH;
				else if (!rx_hdr_ok)
					st = prrf_pkg::STATUS_HEADER;
				else if (rx_crc != {b, rx_crc_lo})
					st = prrf_pkg::STATUS_CRC;
				else
					st = prrf_pkg::STATUS_OK;
				rx_restart();
				if (st != prrf_pkg::STATUS_OK) begin
					owe(prrf_pkg::KIND_REJECT, 8'h00, st, 1'b1);
				end else begin
					for (int i = 0; i < prrf_pkg::PAYLOAD_DEPTH; i++)
						owe(prrf_pkg::KIND_PAYLOAD, rx_payload[i], prrf_pkg::STATUS_OK,
							i == prrf_pkg::PAYLOAD_DEPTH - 1);
				end
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		n_mismatches++;
		$display("[%0t] result %0d: %s", $time, n_results, msg);
	endtask

	task automatic queue_item(input logic opv, input logic [15:0] idx, input logic [7:0] b,
			input logic fin);
		poll_item_t it;
		it.op   = opv;
		it.idx  = idx;
		it.data = b;
		it.fin  = fin;
		// keep the sender busy while the receiver holds off
		if (n_items >= CALM_FROM && n_items < CALM_TO)
			it.gap = 0;
		else
			it.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		it.drain   = drain_next;
		drain_next = 1'b0;
		poll_items.push_back(it);
		n_items++;
	endtask

	task automatic queue_request();
		queue_item(prrf_pkg::OP_REQUEST, 16'($urandom_range(0, 16'hFFFF)),
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Build one response frame, optionally damaged, and queue its bytes.
	task automatic queue_frame(input frame_fault_t fault, input bit extremes);
		logic [7:0]  fb [24];
		logic [15:0] crc;
		int          len;
		for (int i = 0; i < 6; i++)
			fb[i] = RESP_HEAD[8 * (5 - i) +: 8];
		for (int i = 6; i < 16; i++)
			if (extremes)
				fb[i] = i[0] ? 8'hFF : 8'h00;
			else
				fb[i] = 8'($urandom_range(0, 255));
		if (fault == FR_HEADER)
			fb[$urandom_range(0, 5)] ^= 8'h01 << $urandom_range(0, 7);
		crc = prrf_pkg::CRC_INIT;
		for (int i = 0; i < 16; i++)
			crc = crc16_step(crc, fb[i]);
		fb[16] = crc[7:0];
		fb[17] = crc[15:8];
		for (int i = 18; i < 24; i++)
			fb[i] = 8'($urandom_range(0, 255));
		case (fault)
			FR_CRC:   fb[$urandom_range(6, 17)] ^= 8'h01 << $urandom_range(0, 7);
			FR_SHORT: len = $urandom_range(1, 17);
			FR_LONG:  len = $urandom_range(19, 24);
			FR_CUT:   len = $urandom_range(1, 17);
			default:  len = 18;
		endcase
		if (fault == FR_CRC)
			len = 18;
		for (int i = 0; i < len; i++)
			queue_item(prrf_pkg::OP_RECEIVE, 16'($urandom_range(0, 16'hFFFF)), fb[i],
				(i == len - 1) && (fault != FR_CUT));
		// a request drops the half-received frame
		if (fault == FR_CUT)
			queue_request();
	endtask

	// Sender: offer requests from poll_items, honouring the drawn gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_item(op, reg_index, rx_byte, rx_last);
				n_accepted++;
				if (op == prrf_pkg::OP_REQUEST)
					n_requests++;
			end
			if (!in_valid || in_ready) begin
				if (!staged && poll_items.size() != 0) begin
					next_item = poll_items.pop_front();
					staged    = 1'b1;
				end
				if (staged && next_item.gap == 0 &&
						!(next_item.drain && owed_bytes.size() != 0)) begin
					in_valid  <= 1'b1;
					op        <= next_item.op;
					reg_index <= next_item.idx;
					rx_byte   <= next_item.data;
					rx_last   <= next_item.fin;
					staged     = 1'b0;
				end else begin
					in_valid <= 1'b0;
					if (staged && next_item.gap != 0)
						next_item.gap--;
				end
			end
		end
	end

	// Long receiver hold-off, counted on its own.
	always @(posedge clk) begin
		if (!hold_done && n_accepted >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: check each result against the oldest owed one, then draw a stall.
	always @(posedge clk) begin
		framer_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d byte %02h",
						kind, out_byte));
				end else begin
					want = owed_bytes.pop_front();
					if (kind !== want.kind)
						report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
					if (out_byte !== want.data)
						report_mismatch($sformatf("byte %02h, want %02h", out_byte, want.data));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, want %0d", status, want.st));
					if (last !== want.fin)
						report_mismatch($sformatf("last %0b, want %0b", last, want.fin));
				end
				case (kind)
					prrf_pkg::KIND_REQ:     n_req_bytes++;
					prrf_pkg::KIND_PAYLOAD: n_pay_bytes++;
					prrf_pkg::KIND_REJECT:  rejects_by_status[status]++;
					default:                ;
				endcase
				n_results++;
				rdy_wait = ((n_results % 150) >= 100) ? 0 : $urandom_range(0, 17);
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (rdy_wait != 0) begin
				rdy_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int n_directed;
		int pick;
		bit mid_drain;
		rx_restart();
		mid_drain = 1'b0;

		// directed: extreme indexes, ignored fields, one-byte frame, clean frame, cut frame
		queue_item(prrf_pkg::OP_REQUEST, 16'h0000, 8'h00, 1'b0);
		queue_item(prrf_pkg::OP_REQUEST, 16'hFFFF, 8'hFF, 1'b1);
		queue_item(prrf_pkg::OP_RECEIVE, 16'hFFFF, 8'hFF, 1'b1);
		queue_frame(FR_GOOD, 1'b1);
		queue_item(prrf_pkg::OP_RECEIVE, 16'h0000, 8'h00, 1'b0);
		queue_item(prrf_pkg::OP_RECEIVE, 16'hFFFF, 8'h00, 1'b0);
		queue_request();
		n_directed = n_items;

		// hold the sender until everything owed has come out
		drain_next = 1'b1;
		queue_frame(FR_HEADER, 1'b0);
		queue_frame(FR_CRC, 1'b0);
		queue_frame(FR_LONG, 1'b0);
		queue_frame(FR_SHORT, 1'b0);
		while (n_items < n_directed + RANDOM_ITEMS) begin
			if (!mid_drain && n_items >= MID_DRAIN_AT) begin
				drain_next = 1'b1;
				mid_drain  = 1'b1;
			end
			pick = $urandom_range(0, 11);
			if (pick < 4)
				queue_request();
			else if (pick < 9)
				queue_frame(FR_GOOD, 1'b0);
			else if (pick == 9)
				queue_frame(FR_HEADER, 1'b0);
			else if (pick == 10)
				queue_frame(FR_CRC, 1'b0);
			else begin
				case ($urandom_range(0, 3))
					0: queue_frame(FR_SHORT, 1'b0);
					1: queue_frame(FR_LONG, 1'b0);
					2: queue_frame(FR_CUT, 1'b0);
					default:
						repeat ($urandom_range(1, 4))
							queue_item(prrf_pkg::OP_RECEIVE, 16'($urandom_range(0, 16'hFFFF)),
								8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				endcase
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_items)
			@(posedge clk);
		while (owed_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Drove %0d requests (%0d poll frames sent), checked %0d results:",
			n_accepted, n_requests, n_results);
		$display("  %0d request bytes, %0d payload bytes, rejects length/header/crc %0d/%0d/%0d",
			n_req_bytes, n_pay_bytes, rejects_by_status[prrf_pkg::STATUS_LENGTH],
			rejects_by_status[prrf_pkg::STATUS_HEADER], rejects_by_status[prrf_pkg::STATUS_CRC]);
		if (n_mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d requests accepted and %0d results owed",
			n_accepted, owed_bytes.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
